FILE: rtl/halton_radical_inverse_core_defines.svh
// assertion helpers used by the checker file
`ifndef HALTON_RADICAL_INVERSE_CORE_DEFINES_SVH
`define HALTON_RADICAL_INVERSE_CORE_DEFINES_SVH

// same-cycle implication, disabled while rst_n is low
`define HRI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hri assertion failed");

// next-cycle implication, disabled while rst_n is low
`define HRI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hri assertion failed");

`endif

FILE: rtl/hri_pkg.sv
package hri_pkg;

    localparam int DIGIT_BITS = 8;

    typedef logic [DIGIT_BITS-1:0] base_t;

    localparam base_t RADIX_RESET = 8'd3;
    localparam base_t RADIX_MIN   = 8'd2;

endpackage

FILE: rtl/hri_digit.sv
module hri_digit #(
    parameter int IndexBits = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   adv,
    input  hri_pkg::base_t                         base,
    input  logic                                   vld_in,
    input  logic [IndexBits-1:0]                   idx_in,
    input  logic [IndexBits+hri_pkg::DIGIT_BITS-1:0] rev_in,
    input  logic [IndexBits+hri_pkg::DIGIT_BITS-1:0] scale_in,
    output logic                                   vld_out,
    output logic [IndexBits-1:0]                   idx_out,
    output logic [IndexBits+hri_pkg::DIGIT_BITS-1:0] rev_out,
    output logic [IndexBits+hri_pkg::DIGIT_BITS-1:0] scale_out
);
    import hri_pkg::*;

    localparam int SW  = IndexBits + DIGIT_BITS;
    localparam int NCH = (IndexBits + DIGIT_BITS - 1) / DIGIT_BITS;

    // long division by the base, up to DIGIT_BITS quotient bits per stage
    logic                 vld_reg   [NCH];
    logic                 act_reg   [NCH];
    logic [IndexBits-1:0] w_reg     [NCH];
    base_t                r_reg     [NCH];
    logic [SW-1:0]        rev_reg   [NCH];
    logic [SW-1:0]        scale_reg [NCH];

    for (genvar c = 0; c < NCH; c++) begin : g_chunk
        localparam int NSTEP = ((c + 1) * DIGIT_BITS > IndexBits) ?
                               (IndexBits - c * DIGIT_BITS) : DIGIT_BITS;
        logic                 vld_i;
        logic                 act_i;
        logic [IndexBits-1:0] w_i;
        logic [IndexBits-1:0] w_next;
        base_t                r_i;
        base_t                r_next;
        logic [SW-1:0]        rev_i;
        logic [SW-1:0]        scale_i;

        if (c == 0) begin : g_first
            assign vld_i   = vld_in;
            assign act_i   = (idx_in != '0);
            assign w_i     = idx_in;
            assign r_i     = '0;
            assign rev_i   = rev_in;
            assign scale_i = scale_in;
        end else begin : g_rest
            assign vld_i   = vld_reg[c-1];
            assign act_i   = act_reg[c-1];
            assign w_i     = w_reg[c-1];
            assign r_i     = r_reg[c-1];
            assign rev_i   = rev_reg[c-1];
            assign scale_i = scale_reg[c-1];
        end

        always_comb begin
            logic [DIGIT_BITS:0] part;
            w_next = w_i;
            r_next = r_i;
            for (int k = 0; k < NSTEP; k++) begin
                part = {r_next, w_next[IndexBits-1]};
                if (part >= {1'b0, base}) begin
                    part   = part - {1'b0, base};
                    w_next = {w_next[IndexBits-2:0], 1'b1};
                end else begin
                    w_next = {w_next[IndexBits-2:0], 1'b0};
                end
                r_next = part[DIGIT_BITS-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[c] <= 1'b0;
            end else if (adv) begin
                vld_reg[c] <= vld_i;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                act_reg[c]   <= act_i;
                w_reg[c]     <= w_next;
                r_reg[c]     <= r_next;
                rev_reg[c]   <= rev_i;
                scale_reg[c] <= scale_i;
            end
        end
    end

    // append the digit to the mirrored value and grow the scale while the index is nonzero
    logic [SW+DIGIT_BITS-1:0] rev_prod;
    logic [SW+DIGIT_BITS-1:0] scale_prod;
    logic                     vld_o_reg;
    logic [IndexBits-1:0]     idx_o_reg;
    logic [SW-1:0]            rev_o_reg;
    logic [SW-1:0]            scale_o_reg;

    assign rev_prod = {{DIGIT_BITS{1'b0}}, rev_reg[NCH-1]} * {{SW{1'b0}}, base}
                    + {{SW{1'b0}}, r_reg[NCH-1]};
    assign scale_prod = {{DIGIT_BITS{1'b0}}, scale_reg[NCH-1]} * {{SW{1'b0}}, base};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_o_reg <= 1'b0;
        end else if (adv) begin
            vld_o_reg <= vld_reg[NCH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            idx_o_reg <= w_reg[NCH-1];
            if (act_reg[NCH-1]) begin
                rev_o_reg   <= rev_prod[SW-1:0];
                scale_o_reg <= scale_prod[SW-1:0];
            end else begin
                rev_o_reg   <= rev_reg[NCH-1];
                scale_o_reg <= scale_reg[NCH-1];
            end
        end
    end

    assign vld_out   = vld_o_reg;
    assign idx_out   = idx_o_reg;
    assign rev_out   = rev_o_reg;
    assign scale_out = scale_o_reg;

endmodule

FILE: rtl/hri_frac_div.sv
module hri_frac_div #(
    parameter int IndexBits    = 16,
    parameter int FractionBits = 24
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     adv,
    input  logic                                     vld_in,
    input  logic [IndexBits+hri_pkg::DIGIT_BITS-1:0] rem_in,
    input  logic [IndexBits+hri_pkg::DIGIT_BITS-1:0] scale_in,
    output logic                                     vld_out,
    output logic [FractionBits-1:0]                  quot_out
);
    import hri_pkg::*;

    localparam int SW = IndexBits + DIGIT_BITS;

    // restoring division, one quotient bit per stage
    logic                    vld_reg   [FractionBits];
    logic [SW-1:0]           rem_reg   [FractionBits];
    logic [SW-1:0]           scale_reg [FractionBits];
    logic [FractionBits-1:0] quot_reg  [FractionBits];

    for (genvar f = 0; f < FractionBits; f++) begin : g_bit
        logic                    vld_i;
        logic [SW-1:0]           rem_i;
        logic [SW-1:0]           scale_i;
        logic [FractionBits-1:0] quot_i;
        logic [SW:0]             rem_sh;
        logic [SW-1:0]           rem_next;
        logic [FractionBits-1:0] quot_next;

        if (f == 0) begin : g_first
            assign vld_i   = vld_in;
            assign rem_i   = rem_in;
            assign scale_i = scale_in;
            assign quot_i  = '0;
        end else begin : g_rest
            assign vld_i   = vld_reg[f-1];
            assign rem_i   = rem_reg[f-1];
            assign scale_i = scale_reg[f-1];
            assign quot_i  = quot_reg[f-1];
        end

        assign rem_sh = {rem_i, 1'b0};

        always_comb begin
            if (rem_sh >= {1'b0, scale_i}) begin
                rem_next  = SW'(rem_sh - {1'b0, scale_i});
                quot_next = {quot_i[FractionBits-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[SW-1:0];
                quot_next = {quot_i[FractionBits-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[f] <= 1'b0;
            end else if (adv) begin
                vld_reg[f] <= vld_i;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[f]   <= rem_next;
                scale_reg[f] <= scale_i;
                quot_reg[f]  <= quot_next;
            end
        end
    end

    assign vld_out  = vld_reg[FractionBits-1];
    assign quot_out = quot_reg[FractionBits-1];

endmodule

FILE: rtl/halton_radical_inverse_core.sv
// halton radical inverse core
// input channel s_valid/s_ready carries a sample index; result channel
// m_valid/m_ready carries the radical inverse as an unsigned Q0.FRACTION_BITS
// fraction, truncated toward zero. index zero gives zero.
// the base comes from a register written through cfg_wr_en/cfg_wr_data;
// values 0 and 1 act as base 2. write it only while no item is in flight.
// one item may enter every cycle while s_ready is high. each of the
// INDEX_BITS digit steps divides by the base eight bits per stage and then
// multiplies into the mirrored value, and the final division by
// base^ndigits gives one fraction bit per stage.
// the whole pipeline advances together: while a result waits on m_ready,
// s_ready is low and nothing inside moves, so no item is lost or repeated.
// reset clears all valid bits and sets the base to 3.
module halton_radical_inverse_core #(
    parameter int INDEX_BITS    = 16,
    parameter int FRACTION_BITS = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  hri_pkg::base_t           cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [INDEX_BITS-1:0]    s_sample_index,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [FRACTION_BITS-1:0] m_fraction
);
    import hri_pkg::*;

    localparam int SW = INDEX_BITS + DIGIT_BITS;

    base_t radix_reg;
    base_t base_eff;
    logic  adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_wr_en) begin
            radix_reg <= cfg_wr_data;
        end
    end

    assign base_eff = (radix_reg < RADIX_MIN) ? RADIX_MIN : radix_reg;
    assign adv      = !m_valid || m_ready;
    assign s_ready  = adv;

    logic                  dig_vld   [INDEX_BITS+1];
    logic [INDEX_BITS-1:0] dig_idx   [INDEX_BITS+1];
    logic [SW-1:0]         dig_rev   [INDEX_BITS+1];
    logic [SW-1:0]         dig_scale [INDEX_BITS+1];

    assign dig_vld[0]   = s_valid;
    assign dig_idx[0]   = s_sample_index;
    assign dig_rev[0]   = '0;
    assign dig_scale[0] = SW'(1);

    // base-2 indexes need INDEX_BITS digit steps; steps past the last digit pass through
    for (genvar d = 0; d < INDEX_BITS; d++) begin : g_digit
        hri_digit #(
            .IndexBits (INDEX_BITS)
        ) u_digit (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .base      (base_eff),
            .vld_in    (dig_vld[d]),
            .idx_in    (dig_idx[d]),
            .rev_in    (dig_rev[d]),
            .scale_in  (dig_scale[d]),
            .vld_out   (dig_vld[d+1]),
            .idx_out   (dig_idx[d+1]),
            .rev_out   (dig_rev[d+1]),
            .scale_out (dig_scale[d+1])
        );
    end

    hri_frac_div #(
        .IndexBits    (INDEX_BITS),
        .FractionBits (FRACTION_BITS)
    ) u_frac_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .vld_in   (dig_vld[INDEX_BITS]),
        .rem_in   (dig_rev[INDEX_BITS]),
        .scale_in (dig_scale[INDEX_BITS]),
        .vld_out  (m_valid),
        .quot_out (m_fraction)
    );

endmodule

FILE: rtl/hri_checker.sv
`include "halton_radical_inverse_core_defines.svh"

module hri_checker #(
    parameter int FRACTION_BITS = 24
) (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [FRACTION_BITS-1:0] m_fraction
);

    // a waiting result holds still
    `HRI_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_fraction))

    // intake moves exactly when the result slot can drain
    `HRI_ASSERT_NOW(a_ready_follows_out, aclk, aresetn, 1'b1, s_ready == (!m_valid || m_ready))

    // nothing comes out right after reset
    `HRI_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_valid)

endmodule

bind halton_radical_inverse_core hri_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_hri_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_fraction (m_fraction)
);
